// ===== src/hpc_pkg.sv =====
// Package for the heading PI controller: sequencer states, fixed-point
// constants and configuration register indexes. No dependencies.
package hpc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP,
        ST_ABS,
        ST_MUL_P,
        ST_MUL_I,
        ST_STEP,
        ST_ISUM,
        ST_ICLAMP,
        ST_IABS,
        ST_MUL_IK,
        ST_ITERM,
        ST_SUM,
        ST_SABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMB,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] NEG_PI_Q12  = -17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [21:0] GAIN_OFFSET = 22'sd8064;
    localparam logic [36:0]        GAIN_DEN_W  = 37'd23040;
    localparam logic [40:0]        DIV_HALF    = 41'd11520;
    localparam logic [30:0]        RECIP_45    = 31'd1527099484;
    localparam logic [33:0]        Q8_HALF     = 34'd128;
    localparam logic [47:0]        Q8_HALF_W   = 48'd128;
    localparam logic [33:0]        Q16_HALF    = 34'd32768;
    localparam logic signed [25:0] OUT_OFFSET  = 26'sd41;
    localparam logic signed [25:0] DRIVE_MAX   = 26'sd8388607;
    localparam logic signed [25:0] DRIVE_MIN   = -26'sd8388608;

    localparam logic [2:0] REG_KP          = 3'd0;
    localparam logic [2:0] REG_KI          = 3'd1;
    localparam logic [2:0] REG_P_LIMIT     = 3'd2;
    localparam logic [2:0] REG_I_LIMIT     = 3'd3;
    localparam logic [2:0] REG_CTRL_PERIOD = 3'd4;

    localparam logic [15:0] KP_RESET          = 16'd256;
    localparam logic [15:0] KI_RESET          = 16'd0;
    localparam logic [22:0] P_LIMIT_RESET     = 23'd8388607;
    localparam logic [30:0] I_LIMIT_RESET     = 31'd2147483647;
    localparam logic [15:0] CTRL_PERIOD_RESET = 16'd655;

endpackage

// ===== src/heading_pi_controller.sv =====
// Heading PI controller top level: APB register file, sequencer, shared
// multiplier with a reciprocal step for the gain denominator. Uses hpc_pkg.
//
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_current_angle, i_target_angle, i_speed
// output    out        o_valid / i_stall  o_drive
// config    in         APB write/read     paddr, pwdata / prdata
//
// A result is registered at the output once the sequencer has run its states; the
// divide step is skipped when the scaled sum saturates. The next input transfer is
// taken once the sequencer is back in idle. It makes six passes through the shared
// 31x31 multiplier, the last a reciprocal multiply for the gain denominator.
// Reset is synchronous and active low; o_stall is high during reset.
// The block stalls its input while the sequencer runs; a result waiting under
// i_stall does not block the next input transfer, only the next result.
module heading_pi_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_current_angle,
    input  logic signed [15:0] i_target_angle,
    input  logic signed [15:0] i_speed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_drive,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    hpc_pkg::t_state r_state, n_state;

    logic [15:0] r_kp, r_ki, r_ctrl_period;
    logic [22:0] r_p_limit;
    logic [30:0] r_i_limit;

    logic signed [31:0] r_integral;
    logic               r_last_neg;

    logic signed [16:0] r_err;
    logic signed [21:0] r_fac;
    logic [16:0]        r_emag;
    logic               r_eneg;
    logic [19:0]        r_fmag;
    logic               r_fneg;
    logic [61:0]        r_prod;
    logic [22:0]        r_pmag;
    logic [17:0]        r_smag;
    logic signed [23:0] r_psgn;
    logic signed [32:0] r_isum;
    logic [30:0]        r_imag;
    logic               r_ineg;
    logic [38:0]        r_iterm;
    logic signed [40:0] r_sum;
    logic [39:0]        r_amag;
    logic               r_oneg;
    logic [40:0]        r_acc;
    logic [60:0]        r_num;
    logic [23:0]        r_qn;
    logic               r_sat;

    logic               r_out_valid;
    logic signed [23:0] r_drive;

    logic               cfg_wr;
    logic               out_free;
    logic               div_sat;
    logic [30:0]        mul_a;
    logic [30:0]        mul_b;
    logic [61:0]        mul_p;

    logic signed [16:0] diff;
    logic signed [16:0] wrapped;
    logic signed [21:0] fac20;
    logic signed [16:0] err_neg;
    logic signed [21:0] fac_neg;
    logic [33:0]        p_sum;
    logic [25:0]        p_round;
    logic [22:0]        p_mag;
    logic [33:0]        s_sum;
    logic signed [32:0] isum_base;
    logic signed [32:0] isum_step;
    logic signed [32:0] isum_lim;
    logic signed [31:0] integ_neg;
    logic [47:0]        i_sum;
    logic signed [40:0] sum_p;
    logic signed [40:0] sum_i;
    logic signed [40:0] sum_neg;
    logic signed [25:0] q_ext;
    logic signed [25:0] drv_raw;
    logic signed [25:0] drv_sat;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign o_stall  = (r_state != hpc_pkg::ST_IDLE) || !i_rst_n;
    assign o_valid  = r_out_valid;
    assign o_drive  = r_drive;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (paddr[4:2])
            hpc_pkg::REG_KP:          prdata = {16'd0, r_kp};
            hpc_pkg::REG_KI:          prdata = {16'd0, r_ki};
            hpc_pkg::REG_P_LIMIT:     prdata = {9'd0, r_p_limit};
            hpc_pkg::REG_I_LIMIT:     prdata = {1'b0, r_i_limit};
            hpc_pkg::REG_CTRL_PERIOD: prdata = {16'd0, r_ctrl_period};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= hpc_pkg::KP_RESET;
            r_ki          <= hpc_pkg::KI_RESET;
            r_p_limit     <= hpc_pkg::P_LIMIT_RESET;
            r_i_limit     <= hpc_pkg::I_LIMIT_RESET;
            r_ctrl_period <= hpc_pkg::CTRL_PERIOD_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                hpc_pkg::REG_KP:          r_kp          <= pwdata[15:0];
                hpc_pkg::REG_KI:          r_ki          <= pwdata[15:0];
                hpc_pkg::REG_P_LIMIT:     r_p_limit     <= pwdata[22:0];
                hpc_pkg::REG_I_LIMIT:     r_i_limit     <= pwdata[30:0];
                hpc_pkg::REG_CTRL_PERIOD: r_ctrl_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            hpc_pkg::ST_MUL_P: begin
                mul_a = {14'd0, r_emag};
                mul_b = {15'd0, r_kp};
            end
            hpc_pkg::ST_MUL_I: begin
                mul_a = {14'd0, r_emag};
                mul_b = {15'd0, r_ctrl_period};
            end
            hpc_pkg::ST_MUL_IK: begin
                mul_a = r_imag;
                mul_b = {15'd0, r_ki};
            end
            hpc_pkg::ST_MUL_LO: begin
                mul_a = {11'd0, r_amag[19:0]};
                mul_b = {11'd0, r_fmag};
            end
            hpc_pkg::ST_MUL_HI: begin
                mul_a = {11'd0, r_amag[39:20]};
                mul_b = {11'd0, r_fmag};
            end
            hpc_pkg::ST_DIV_INIT: begin
                mul_a = {1'b0, r_num[38:9]};
                mul_b = hpc_pkg::RECIP_45;
            end
            default: begin
                mul_a = 31'd0;
                mul_b = 31'd0;
            end
        endcase
    end

    assign mul_p = {31'd0, mul_a} * {31'd0, mul_b};

    always_comb begin
        diff    = 17'(i_target_angle) - 17'(i_current_angle);
        fac20   = (22'(i_speed) <<< 4) + (22'(i_speed) <<< 2);
        if (r_err > hpc_pkg::PI_Q12) begin
            wrapped = r_err - hpc_pkg::TWO_PI_Q12;
        end else if (r_err < hpc_pkg::NEG_PI_Q12) begin
            wrapped = r_err + hpc_pkg::TWO_PI_Q12;
        end else begin
            wrapped = r_err;
        end
        err_neg = -r_err;
        fac_neg = -r_fac;

        p_sum   = {1'b0, r_prod[32:0]} + hpc_pkg::Q8_HALF;
        p_round = p_sum[33:8];
        p_mag   = (p_round > {3'd0, r_p_limit}) ? r_p_limit : p_round[22:0];
        s_sum   = {1'b0, r_prod[32:0]} + hpc_pkg::Q16_HALF;

        isum_base = 33'(r_integral);
        isum_step = $signed({15'd0, r_smag});
        isum_lim  = $signed({2'd0, r_i_limit});
        integ_neg = -r_integral;

        i_sum   = {1'b0, r_prod[46:0]} + hpc_pkg::Q8_HALF_W;
        sum_p   = 41'(r_psgn);
        sum_i   = $signed({2'd0, r_iterm});
        sum_neg = -r_sum;

        div_sat = (r_num[60:24] >= hpc_pkg::GAIN_DEN_W);

        q_ext   = $signed({2'd0, r_qn});
        drv_raw = r_oneg ? (hpc_pkg::OUT_OFFSET - q_ext) : (q_ext + hpc_pkg::OUT_OFFSET);
        if (r_sat) begin
            drv_sat = r_oneg ? hpc_pkg::DRIVE_MIN : hpc_pkg::DRIVE_MAX;
        end else if (drv_raw > hpc_pkg::DRIVE_MAX) begin
            drv_sat = hpc_pkg::DRIVE_MAX;
        end else if (drv_raw < hpc_pkg::DRIVE_MIN) begin
            drv_sat = hpc_pkg::DRIVE_MIN;
        end else begin
            drv_sat = drv_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            hpc_pkg::ST_IDLE:     n_state = i_valid ? hpc_pkg::ST_WRAP : hpc_pkg::ST_IDLE;
            hpc_pkg::ST_WRAP:     n_state = hpc_pkg::ST_ABS;
            hpc_pkg::ST_ABS:      n_state = hpc_pkg::ST_MUL_P;
            hpc_pkg::ST_MUL_P:    n_state = hpc_pkg::ST_MUL_I;
            hpc_pkg::ST_MUL_I:    n_state = hpc_pkg::ST_STEP;
            hpc_pkg::ST_STEP:     n_state = hpc_pkg::ST_ISUM;
            hpc_pkg::ST_ISUM:     n_state = hpc_pkg::ST_ICLAMP;
            hpc_pkg::ST_ICLAMP:   n_state = hpc_pkg::ST_IABS;
            hpc_pkg::ST_IABS:     n_state = hpc_pkg::ST_MUL_IK;
            hpc_pkg::ST_MUL_IK:   n_state = hpc_pkg::ST_ITERM;
            hpc_pkg::ST_ITERM:    n_state = hpc_pkg::ST_SUM;
            hpc_pkg::ST_SUM:      n_state = hpc_pkg::ST_SABS;
            hpc_pkg::ST_SABS:     n_state = hpc_pkg::ST_MUL_LO;
            hpc_pkg::ST_MUL_LO:   n_state = hpc_pkg::ST_MUL_HI;
            hpc_pkg::ST_MUL_HI:   n_state = hpc_pkg::ST_COMB;
            hpc_pkg::ST_COMB:     n_state = hpc_pkg::ST_DIV_INIT;
            hpc_pkg::ST_DIV_INIT: n_state = div_sat ? hpc_pkg::ST_OUT : hpc_pkg::ST_DIV;
            hpc_pkg::ST_DIV:      n_state = hpc_pkg::ST_OUT;
            hpc_pkg::ST_OUT:      n_state = out_free ? hpc_pkg::ST_IDLE : hpc_pkg::ST_OUT;
            default:              n_state = hpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            hpc_pkg::ST_IDLE: begin
                r_err <= diff;
                r_fac <= fac20;
            end
            hpc_pkg::ST_WRAP: begin
                r_err <= wrapped;
                r_fac <= r_fac + hpc_pkg::GAIN_OFFSET;
            end
            hpc_pkg::ST_ABS: begin
                r_eneg <= r_err[16];
                r_emag <= r_err[16] ? $unsigned(err_neg) : $unsigned(r_err);
                r_fneg <= r_fac[21];
                r_fmag <= r_fac[21] ? fac_neg[19:0] : r_fac[19:0];
            end
            hpc_pkg::ST_MUL_I: begin
                r_pmag <= p_mag;
            end
            hpc_pkg::ST_STEP: begin
                r_smag <= s_sum[33:16];
            end
            hpc_pkg::ST_ISUM: begin
                r_psgn <= r_eneg ? -$signed({1'b0, r_pmag}) : $signed({1'b0, r_pmag});
                if (r_eneg != r_last_neg) begin
                    r_isum <= '0;
                end else if (r_eneg) begin
                    r_isum <= isum_base - isum_step;
                end else begin
                    r_isum <= isum_base + isum_step;
                end
            end
            hpc_pkg::ST_IABS: begin
                r_ineg <= r_integral[31];
                r_imag <= r_integral[31] ? integ_neg[30:0] : r_integral[30:0];
            end
            hpc_pkg::ST_ITERM: begin
                r_iterm <= i_sum[46:8];
            end
            hpc_pkg::ST_SUM: begin
                r_sum <= r_ineg ? (sum_p - sum_i) : (sum_p + sum_i);
            end
            hpc_pkg::ST_SABS: begin
                r_oneg <= r_sum[40] ^ r_fneg;
                r_amag <= r_sum[40] ? sum_neg[39:0] : r_sum[39:0];
            end
            hpc_pkg::ST_MUL_HI: begin
                r_acc <= {1'b0, r_prod[39:0]} + hpc_pkg::DIV_HALF;
            end
            hpc_pkg::ST_COMB: begin
                r_num <= {1'b0, r_prod[39:0], 20'd0} + {20'd0, r_acc};
            end
            hpc_pkg::ST_DIV_INIT: begin
                r_sat <= div_sat;
            end
            hpc_pkg::ST_DIV: begin
                r_qn <= r_prod[59:36];
            end
            default: ;
        endcase
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_neg <= 1'b0;
        end else if (r_state == hpc_pkg::ST_ICLAMP) begin
            r_last_neg <= r_eneg;
            if (r_isum > isum_lim) begin
                r_integral <= 32'(isum_lim);
            end else if (r_isum < -isum_lim) begin
                r_integral <= 32'(-isum_lim);
            end else begin
                r_integral <= 32'(r_isum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == hpc_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hpc_pkg::ST_OUT && out_free) begin
            r_drive <= drv_sat[23:0];
        end
    end

endmodule

// ===== src/hpc_checker.sv =====
// Port-level checker for heading_pi_controller, bound to the top level.
// Depends only on the top-level ports.
module hpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [23:0] o_drive
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transfer");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid))
        else $error("result raised right after input transfer");

    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_stall) && $past(i_rst_n)) |-> o_valid)
        else $error("sequencer released without a result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_drive)))
        else $error("stalled result changed");

endmodule

bind heading_pi_controller hpc_checker u_hpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_drive (o_drive)
);

// ===== bench/heading_pi_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heading_pi_controller: drives control ticks and APB
// register writes, predicts each drive value in fixed point and compares it.
// Depends on hpc_pkg and heading_pi_controller from src.
module heading_pi_controller_tb;

    localparam int     LATENCY     = 42;
    localparam int     HOLD_CYCLES = 400;
    localparam longint HALF_TURN   = 12868;
    localparam longint FULL_TURN   = 25736;
    localparam longint GAIN_SLOPE  = 20;
    localparam longint GAIN_BIAS   = 8064;
    localparam longint GAIN_DIV    = 23040;
    localparam longint OFFSET_Q12  = 41;
    localparam longint DRIVE_HI    = 8388607;
    localparam longint DRIVE_LO    = -8388608;

    typedef struct {
        logic signed [15:0] cur;
        logic signed [15:0] tgt;
        logic signed [15:0] spd;
    } t_tick;

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_current_angle = '0;
    logic signed [15:0] i_target_angle  = '0;
    logic signed [15:0] i_speed         = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic signed [23:0] o_drive;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [4:0]         paddr           = '0;
    logic [31:0]        pwdata          = '0;
    logic [31:0]        prdata;
    logic               pready;

    longint kp_q     = 256;
    longint ki_q     = 0;
    longint plim_q   = 8388607;
    longint ilim_q   = 2147483647;
    longint period_q = 655;
    longint integ_sum = 0;
    bit     integ_neg = 1'b0;

    logic signed [23:0] drive_q[$];
    int       fail_count = 0;
    int       burst_left = 0;
    bit       drift_neg  = 1'b0;
    bit       hold_req   = 1'b0;
    int       hold_left  = 0;
    t_rx_mode rx_mode    = RX_FREE;
    int       rx_left    = 0;

    heading_pi_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_current_angle (i_current_angle),
        .i_target_angle  (i_target_angle),
        .i_speed         (i_speed),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (o_drive),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint round_div(longint n, longint d);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic longint clamp_abs(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic logic signed [23:0] next_drive(t_tick t);
        longint err, p, isum, iterm, acc, d;
        bit     neg;
        err = longint'(t.tgt) - longint'(t.cur);
        if (err > HALF_TURN) err -= FULL_TURN;
        else if (err < -HALF_TURN) err += FULL_TURN;
        p = clamp_abs(round_div(err * kp_q, 256), plim_q);
        isum = integ_sum + round_div(err * period_q, 65536);
        neg = (err < 0);
        if (neg != integ_neg) isum = 0;
        integ_neg = neg;
        isum = clamp_abs(isum, ilim_q);
        integ_sum = isum;
        iterm = round_div(isum * ki_q, 256);
        acc = p + iterm;
        d = round_div(acc * (GAIN_SLOPE * longint'(t.spd) + GAIN_BIAS), GAIN_DIV) + OFFSET_Q12;
        if (d > DRIVE_HI) d = DRIVE_HI;
        if (d < DRIVE_LO) d = DRIVE_LO;
        return d[23:0];
    endfunction

    function automatic t_tick mk(int c, int t, int s);
        t_tick r;
        r.cur = 16'(c);
        r.tgt = 16'(t);
        r.spd = 16'(s);
        return r;
    endfunction

    function automatic t_tick rand_tick();
        t_tick r;
        int    delta;
        if ($urandom_range(0, 9) == 0) drift_neg = !drift_neg;
        r.cur = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            r.tgt = 16'($urandom);
        end else begin
            delta = $urandom_range(0, 3000);
            if (drift_neg ^ ($urandom_range(0, 5) == 0)) delta = -delta;
            r.tgt = 16'(int'(r.cur) + delta);
        end
        if ($urandom_range(0, 1) == 0) r.spd = 16'($urandom);
        else r.spd = 16'(int'($urandom_range(0, 2400)) - 600);
        return r;
    endfunction

    function automatic logic [31:0] pick_field(int bits);
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 512);
            2: return $urandom_range(0, 4096);
            3: return 32'((64'd1 << bits) - 1);
            default: return $urandom() & 32'((64'd1 << bits) - 1);
        endcase
    endfunction

    task automatic send_tick(t_tick t);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_current_angle <= t.cur;
        i_target_angle  <= t.tgt;
        i_speed         <= t.spd;
        do @(posedge i_clk); while (o_stall);
        drive_q.push_back(next_drive(t));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            hpc_pkg::REG_KP:          kp_q     = val[15:0];
            hpc_pkg::REG_KI:          ki_q     = val[15:0];
            hpc_pkg::REG_P_LIMIT:     plim_q   = val[22:0];
            hpc_pkg::REG_I_LIMIT:     ilim_q   = val[30:0];
            hpc_pkg::REG_CTRL_PERIOD: period_q = val[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] plim,
                             logic [31:0] ilim, logic [31:0] period);
        write_reg(hpc_pkg::REG_KP, kp);
        write_reg(hpc_pkg::REG_KI, ki);
        write_reg(hpc_pkg::REG_P_LIMIT, plim);
        write_reg(hpc_pkg::REG_I_LIMIT, ilim);
        write_reg(hpc_pkg::REG_CTRL_PERIOD, period);
    endtask

    task automatic test_directed();
        send_tick(mk(0, 0, 0));
        send_tick(mk(0, 4096, 256));
        send_tick(mk(4096, 0, 256));
        send_tick(mk(0, 12868, 0));
        send_tick(mk(0, 12869, 1000));
        send_tick(mk(0, -12868, -1000));
        send_tick(mk(0, -12869, -403));
        send_tick(mk(-32768, 32767, 32767));
        send_tick(mk(32767, -32768, -32768));
        send_tick(mk(5, 5, -404));
        wait_drain();
        write_all(32'd65535, 32'd256, 32'h7FFFFF, 32'h7FFFFFFF, 32'd65535);
        send_tick(mk(0, 100, 0));
        send_tick(mk(0, 100, 0));
        send_tick(mk(0, -1, 0));
        send_tick(mk(0, 0, 0));
        send_tick(mk(1000, 1000, 32767));
        send_tick(mk(-32768, 32767, 32767));
        send_tick(mk(32767, -32768, 32767));
        send_tick(mk(-20000, 20000, -32768));
    endtask

    task automatic test_register_extremes();
        for (int s = 0; s < 4; s++) begin
            wait_drain();
            case (s)
                0: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                1: write_all(32'd65535, 32'd65535, 32'h7FFFFF, 32'h7FFFFFFF, 32'd65535);
                2: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                default: write_all(32'd256, 32'd65535, 32'd1, 32'd1, 32'd65535);
            endcase
            for (int idx = int'(hpc_pkg::REG_CTRL_PERIOD) + 1; idx < 8; idx++)
                write_reg(3'(idx), $urandom());
            repeat (12) send_tick(rand_tick());
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        write_all(32'd300, 32'd40, 32'h7FFFFF, 32'd200000, 32'd655);
        hold_req = 1'b1;
        do @(posedge i_clk); while (hold_left == 0);
        burst_left = 12;
        repeat (12) send_tick(rand_tick());
    endtask

    task automatic test_drain_pause();
        repeat (20) send_tick(rand_tick());
        wait_drain();
        repeat (20) send_tick(rand_tick());
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            wait_drain();
            write_all(pick_field(16), pick_field(16), pick_field(23), pick_field(31),
                      pick_field(16));
            repeat (105) send_tick(rand_tick());
        end
    endtask

    always @(posedge i_clk) begin
        logic signed [23:0] want;
        if (o_valid && !i_stall) begin
            if (drive_q.size() == 0) begin
                $error("unexpected drive transfer: actual %0d", o_drive);
                fail_count++;
            end else begin
                want = drive_q.pop_front();
                if (o_drive !== want) begin
                    $error("drive mismatch: expected %0d, actual %0d", want, o_drive);
                    fail_count++;
                end
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 4) != 0);
                default:  i_stall <= rx_left[1];
            endcase
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_drain_pause();
        test_random();
        wait_drain();
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
